>>> rtl/drdm_pkg.sv
// ----------------------------------------------------------------------------
// drdm_pkg
// Shared types and constants for the dual ring deque mover.
// ----------------------------------------------------------------------------
package drdm_pkg;

	// Default sizes, handed to the top level parameters
	localparam int CAPACITY_DEF  = 64;
	localparam int WORD_BITS_DEF = 32;

	// Fixed port widths
	localparam int VALUE_W = 32;
	localparam int LEN_W   = 7;
	localparam int OP_W    = 2;
	localparam int CMD_W   = 4;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
	localparam logic [OP_W-1:0] OP_POP  = 2'd1;
	localparam logic [OP_W-1:0] OP_MOVE = 2'd2;

	// Command bit positions
	localparam int CMD_SRC_RIGHT = 3;
	localparam int CMD_POP_BACK  = 2;
	localparam int CMD_DST_RIGHT = 1;
	localparam int CMD_PUSH_BACK = 0;

	// Controller states
	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Per-deque request for one transaction
	typedef struct packed {
		logic pop;
		logic pop_back;
		logic push;
		logic push_back;
	} deq_req_t;

endpackage

>>> rtl/drdm_ram.sv
// ----------------------------------------------------------------------------
// drdm_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module drdm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/drdm_deque.sv
// ----------------------------------------------------------------------------
// drdm_deque
// One circular deque: front/back pointers, element count and its storage RAM.
// A transaction may pop, then push, on the same deque in one commit.
// ----------------------------------------------------------------------------
module drdm_deque #(
	parameter int CAPACITY  = drdm_pkg::CAPACITY_DEF,
	parameter int WORD_BITS = drdm_pkg::WORD_BITS_DEF,
	localparam int PTR_W    = $clog2(CAPACITY),
	localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// read request, issued when the transaction is accepted
	input  logic                     rd_en,
	input  logic                     rd_back,
	output logic [WORD_BITS-1:0]     rd_data,
	// update, once the transaction executes
	input  logic                     commit,
	input  drdm_pkg::deq_req_t       req,
	input  logic [WORD_BITS-1:0]     push_data,
	output logic [CNT_W-1:0]         count,
	output logic [CNT_W-1:0]         count_next
);

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

	logic [PTR_W-1:0] front_q, back_q;
	logic [CNT_W-1:0] count_q;

	logic [PTR_W-1:0] front_p, back_p;     // after pop
	logic [CNT_W-1:0] count_p;
	logic [PTR_W-1:0] front_n, back_n;     // after push
	logic [CNT_W-1:0] count_n;
	logic [PTR_W-1:0] wr_idx;
	logic [PTR_W-1:0] rd_addr;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_LAST : p - PTR_W'(1);
	endfunction

	// Pop step; caller only pops a non-empty deque
	always_comb begin
		front_p = front_q;
		back_p  = back_q;
		count_p = count_q;
		if (req.pop) begin
			if (count_q <= CNT_W'(1)) begin
				count_p = '0;
			end else begin
				count_p = count_q - CNT_W'(1);
				if (req.pop_back) begin
					back_p = ptr_prev(back_q);
				end else begin
					front_p = ptr_next(front_q);
				end
			end
		end
	end

	// Push step on the post-pop state; a full deque drops the far end
	always_comb begin
		front_n = front_p;
		back_n  = back_p;
		count_n = count_p;
		wr_idx  = req.push_back ? back_p : front_p;
		if (req.push) begin
			if (count_p == '0) begin
				count_n = CNT_W'(1);
			end else if (req.push_back) begin
				wr_idx = ptr_next(back_p);
				if (count_p >= CNT_FULL) begin
					front_n = ptr_next(front_p);
				end else begin
					count_n = count_p + CNT_W'(1);
				end
			end else begin
				wr_idx = ptr_prev(front_p);
				if (count_p >= CNT_FULL) begin
					back_n = ptr_prev(back_p);
				end else begin
					count_n = count_p + CNT_W'(1);
				end
			end
			if (req.push_back) begin
				back_n = wr_idx;
			end else begin
				front_n = wr_idx;
			end
		end
	end

	// Pointer and count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else if (commit) begin
			front_q <= front_n;
			back_q  <= back_n;
			count_q <= count_n;
		end
	end

	assign rd_addr    = rd_back ? back_q : front_q;
	assign count      = count_q;
	assign count_next = count_n;

	drdm_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (commit & req.push),
		.waddr (wr_idx),
		.wdata (push_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

endmodule

>>> rtl/dual_ring_deque_mover_top.sv
// ----------------------------------------------------------------------------
// dual_ring_deque_mover_top
// Two circular deques (left, right) with push, pop and move between them.
//
//   channel | signals                                   | dir
//   --------+-------------------------------------------+-----
//   in      | in_valid, in_stall, op, command, value    | in
//   out     | out_valid, out_stall, taken_value,        | out
//           | taken_valid, left_length, right_length    |
//
// An accepted transaction issues the source RAM read; the EXEC state then
// commits pointers, counts and the push write.
// One transaction is in flight at a time; the result sits in an output
// register so the next transaction is accepted while it waits.
// Reset (arst_n low) empties both deques; no RAM clearing is needed.
// A stalled output holds the commit cycle until the result register frees.
// ----------------------------------------------------------------------------
module dual_ring_deque_mover_top #(
	parameter int CAPACITY  = drdm_pkg::CAPACITY_DEF,
	parameter int WORD_BITS = drdm_pkg::WORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [drdm_pkg::OP_W-1:0]            op,
	input  logic [drdm_pkg::CMD_W-1:0]           command,
	input  logic signed [drdm_pkg::VALUE_W-1:0]  value,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [drdm_pkg::VALUE_W-1:0]  taken_value,
	output logic                                 taken_valid,
	output logic [drdm_pkg::LEN_W-1:0]           left_length,
	output logic [drdm_pkg::LEN_W-1:0]           right_length
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	drdm_pkg::state_t state_q, state_d;

	logic                                in_fire;
	logic                                exec_go;
	logic [drdm_pkg::OP_W-1:0]           op_s1;
	logic [drdm_pkg::CMD_W-1:0]          cmd_s1;
	logic signed [drdm_pkg::VALUE_W-1:0] value_s1;

	logic [WORD_BITS-1:0]                l_rdata, r_rdata, src_rdata, push_data;
	logic [CNT_W-1:0]                    l_count, r_count, l_count_n, r_count_n;
	logic                                src_right, dst_right, src_nonempty;
	logic                                do_take, do_push;
	drdm_pkg::deq_req_t                  l_req, r_req;

	logic                                out_valid_q;
	logic signed [drdm_pkg::VALUE_W-1:0] taken_value_q;
	logic                                taken_valid_q;
	logic [drdm_pkg::LEN_W-1:0]          left_length_q, right_length_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			drdm_pkg::ST_IDLE: begin
				if (in_valid) state_d = drdm_pkg::ST_EXEC;
			end
			drdm_pkg::ST_EXEC: begin
				if (!out_valid_q || !out_stall) state_d = drdm_pkg::ST_IDLE;
			end
			default: state_d = drdm_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_stall = 1'b1;
		exec_go  = 1'b0;
		unique case (state_q)
			drdm_pkg::ST_IDLE: in_stall = 1'b0;
			drdm_pkg::ST_EXEC: exec_go  = !out_valid_q || !out_stall;
			default: begin
				in_stall = 1'b1;
				exec_go  = 1'b0;
			end
		endcase
	end

	assign in_fire = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= drdm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Transaction capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1    <= op;
			cmd_s1   <= command;
			value_s1 <= value;
		end
	end

	// Decode of the captured transaction
	always_comb begin
		src_right    = cmd_s1[drdm_pkg::CMD_SRC_RIGHT];
		dst_right    = cmd_s1[drdm_pkg::CMD_DST_RIGHT];
		src_nonempty = src_right ? (r_count != '0) : (l_count != '0);
		do_take      = ((op_s1 == drdm_pkg::OP_POP) || (op_s1 == drdm_pkg::OP_MOVE))
		               && src_nonempty;
		do_push      = (op_s1 == drdm_pkg::OP_PUSH)
		               || ((op_s1 == drdm_pkg::OP_MOVE) && src_nonempty);
		src_rdata    = src_right ? r_rdata : l_rdata;
		push_data    = (op_s1 == drdm_pkg::OP_MOVE) ? src_rdata : WORD_BITS'(value_s1);

		l_req.pop       = do_take && !src_right;
		l_req.pop_back  = cmd_s1[drdm_pkg::CMD_POP_BACK];
		l_req.push      = do_push && !dst_right;
		l_req.push_back = cmd_s1[drdm_pkg::CMD_PUSH_BACK];
		r_req.pop       = do_take && src_right;
		r_req.pop_back  = cmd_s1[drdm_pkg::CMD_POP_BACK];
		r_req.push      = do_push && dst_right;
		r_req.push_back = cmd_s1[drdm_pkg::CMD_PUSH_BACK];
	end

	drdm_deque #(
		.CAPACITY  (CAPACITY),
		.WORD_BITS (WORD_BITS)
	) u_left (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (in_fire),
		.rd_back    (command[drdm_pkg::CMD_POP_BACK]),
		.rd_data    (l_rdata),
		.commit     (exec_go),
		.req        (l_req),
		.push_data  (push_data),
		.count      (l_count),
		.count_next (l_count_n)
	);

	drdm_deque #(
		.CAPACITY  (CAPACITY),
		.WORD_BITS (WORD_BITS)
	) u_right (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (in_fire),
		.rd_back    (command[drdm_pkg::CMD_POP_BACK]),
		.rd_data    (r_rdata),
		.commit     (exec_go),
		.req        (r_req),
		.push_data  (push_data),
		.count      (r_count),
		.count_next (r_count_n)
	);

	// Result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (exec_go) begin
			taken_value_q  <= do_take ? drdm_pkg::VALUE_W'($signed(src_rdata)) : '0;
			taken_valid_q  <= do_take;
			left_length_q  <= drdm_pkg::LEN_W'(l_count_n);
			right_length_q <= drdm_pkg::LEN_W'(r_count_n);
		end
	end

	assign out_valid    = out_valid_q;
	assign taken_value  = taken_value_q;
	assign taken_valid  = taken_valid_q;
	assign left_length  = left_length_q;
	assign right_length = right_length_q;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the dual ring deque mover against a cycle-free mirror of both
// deques. Every accepted transaction updates the mirror and queues the
// expected result; every accepted result is compared field by field.
// Stimulus: a directed opening, then random segments that fill, drain or
// mix the deques, under three idling profiles and one long output hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import drdm_pkg::*;

	localparam int DEPTH        = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 1430;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 8;

	// Op code the block leaves unused
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// Deque indexes in the mirror
	localparam int SIDE_LEFT  = 0;
	localparam int SIDE_RIGHT = 1;

	typedef enum int {
		MODE_FILL,
		MODE_DRAIN,
		MODE_MIX
	} seg_mode_t;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic                      valid;
		logic [LEN_W-1:0]          left_len;
		logic [LEN_W-1:0]          right_len;
	} taken_t;

	// Mirror of both deques plus the queue of results still to arrive
	class deque_scoreboard;
		logic [VALUE_W-1:0] ring [2][DEPTH];
		int front [2];
		int back [2];
		int count [2];
		taken_t pending_taken [$];
		int errors;

		function new();
			for (int s = 0; s < 2; s++) begin
				front[s] = 0;
				back[s]  = 0;
				count[s] = 0;
			end
			errors = 0;
		endfunction

		// Push with overwrite: a full deque drops the element at the other end
		function void push_word(int s, bit at_back, logic [VALUE_W-1:0] w);
			int slot;
			if (count[s] == 0) begin
				slot     = at_back ? back[s] : front[s];
				count[s] = 1;
			end else if (at_back) begin
				slot = (back[s] + 1) % DEPTH;
				if (count[s] >= DEPTH)
					front[s] = (front[s] + 1) % DEPTH;
				else
					count[s]++;
			end else begin
				slot = (front[s] + DEPTH - 1) % DEPTH;
				if (count[s] >= DEPTH)
					back[s] = (back[s] + DEPTH - 1) % DEPTH;
				else
					count[s]++;
			end
			ring[s][slot] = w;
			if (at_back)
				back[s] = slot;
			else
				front[s] = slot;
		endfunction

		// Pop from a non-empty deque; the last element leaves pointers in place
		function logic [VALUE_W-1:0] pop_word(int s, bit at_back);
			int slot;
			logic [VALUE_W-1:0] w;
			slot = at_back ? back[s] : front[s];
			w    = ring[s][slot];
			if (count[s] <= 1) begin
				count[s] = 0;
			end else begin
				count[s]--;
				if (at_back)
					back[s] = (back[s] + DEPTH - 1) % DEPTH;
				else
					front[s] = (front[s] + 1) % DEPTH;
			end
			return w;
		endfunction

		// Accepted transaction: advance the mirror, queue the expected result
		function void note_request(logic [OP_W-1:0] op_code, logic [CMD_W-1:0] cmd,
				logic [VALUE_W-1:0] val);
			taken_t r;
			int src;
			int dst;
			logic [VALUE_W-1:0] w;
			src     = cmd[CMD_SRC_RIGHT] ? SIDE_RIGHT : SIDE_LEFT;
			dst     = cmd[CMD_DST_RIGHT] ? SIDE_RIGHT : SIDE_LEFT;
			r.value = '0;
			r.valid = 1'b0;
			case (op_code)
				OP_PUSH: push_word(dst, cmd[CMD_PUSH_BACK], val);
				OP_POP, OP_MOVE: begin
					if (count[src] != 0) begin
						w = pop_word(src, cmd[CMD_POP_BACK]);
						if (op_code == OP_MOVE)
							push_word(dst, cmd[CMD_PUSH_BACK], w);
						r.value = w;
						r.valid = 1'b1;
					end
				end
				default: ;
			endcase
			r.left_len  = LEN_W'(count[SIDE_LEFT]);
			r.right_len = LEN_W'(count[SIDE_RIGHT]);
			pending_taken.push_back(r);
		endfunction

		// Accepted result: compare with the oldest expectation
		function void check_taken(logic signed [VALUE_W-1:0] v, logic ok,
				logic [LEN_W-1:0] l_len, logic [LEN_W-1:0] r_len);
			taken_t e;
			if (pending_taken.size() == 0) begin
				$error("result arrived with no transaction pending");
				errors++;
				return;
			end
			e = pending_taken.pop_front();
			if (v !== e.value) begin
				$error("taken_value: expected %0d, got %0d", e.value, v);
				errors++;
			end
			if (ok !== e.valid) begin
				$error("taken_valid: expected %0d, got %0d", e.valid, ok);
				errors++;
			end
			if (l_len !== e.left_len) begin
				$error("left_length: expected %0d, got %0d", e.left_len, l_len);
				errors++;
			end
			if (r_len !== e.right_len) begin
				$error("right_length: expected %0d, got %0d", e.right_len, r_len);
				errors++;
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [OP_W-1:0]           op = OP_PUSH;
	logic [CMD_W-1:0]          command = '0;
	logic signed [VALUE_W-1:0] value = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [VALUE_W-1:0] taken_value;
	logic                      taken_valid;
	logic [LEN_W-1:0]          left_length;
	logic [LEN_W-1:0]          right_length;

	deque_scoreboard sb;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	dual_ring_deque_mover_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.command      (command),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.taken_value  (taken_value),
		.taken_valid  (taken_valid),
		.left_length  (left_length),
		.right_length (right_length)
	);

	always #2 clk = ~clk;

	function automatic logic [CMD_W-1:0] cmd_of(bit src_right, bit pop_back,
			bit dst_right, bit push_back);
		logic [CMD_W-1:0] c;
		c = '0;
		c[CMD_SRC_RIGHT] = src_right;
		c[CMD_POP_BACK]  = pop_back;
		c[CMD_DST_RIGHT] = dst_right;
		c[CMD_PUSH_BACK] = push_back;
		return c;
	endfunction

	// Offer one transaction after a random gap and wait for its acceptance
	task automatic send_item(input logic [OP_W-1:0] o, input logic [CMD_W-1:0] c,
			input logic [VALUE_W-1:0] v);
		int gap;
		gap = 0;
		while ($urandom_range(99) < snd_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		command  <= c;
		value    <= v;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_request(o, c, v);
	endtask

	task automatic wait_drained();
		while (sb.pending_taken.size() != 0)
			@(posedge clk);
	endtask

	// Result side: check accepted results, drive random stall and long holds
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall)
			sb.check_taken(taken_value, taken_valid, left_length, right_length);
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// Watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int seg_len;
		int n;
		int r;
		int push_pct;
		int take_pct;
		bit fav;
		seg_mode_t mode;
		logic [OP_W-1:0] o;
		logic [CMD_W-1:0] c;
		logic [VALUE_W-1:0] v;

		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty sources, unused op, extreme values, every end
		snd_idle_pct = 20;
		rcv_idle_pct = 20;
		send_item(OP_POP, cmd_of(0, 0, 0, 0), 32'h1234_5678);
		send_item(OP_POP, cmd_of(1, 1, 0, 0), '0);
		send_item(OP_MOVE, cmd_of(1, 0, 0, 1), '0);
		send_item(OP_UNUSED, cmd_of(1, 1, 1, 1), '1);
		send_item(OP_PUSH, cmd_of(0, 0, 0, 0), 32'h7FFF_FFFF);
		send_item(OP_PUSH, cmd_of(0, 0, 0, 1), 32'h8000_0000);
		send_item(OP_PUSH, cmd_of(0, 0, 1, 1), 32'hFFFF_FFFF);
		send_item(OP_PUSH, cmd_of(0, 0, 1, 0), 32'h0000_0000);
		send_item(OP_PUSH, cmd_of(1, 1, 1, 1), 32'h5555_5555);
		send_item(OP_PUSH, cmd_of(1, 1, 0, 0), 32'hAAAA_AAAA);
		send_item(OP_UNUSED, cmd_of(0, 0, 0, 0), 32'h0000_0001);
		send_item(OP_MOVE, cmd_of(0, 0, 1, 1), '0);
		send_item(OP_MOVE, cmd_of(1, 1, 1, 0), '0);
		send_item(OP_MOVE, cmd_of(0, 1, 0, 0), '0);
		send_item(OP_MOVE, cmd_of(1, 0, 0, 1), '0);
		send_item(OP_POP, cmd_of(0, 1, 1, 1), '1);
		send_item(OP_POP, cmd_of(1, 0, 0, 0), '0);
		send_item(OP_POP, cmd_of(1, 1, 0, 0), '0);
		send_item(OP_POP, cmd_of(0, 0, 0, 0), '0);
		send_item(OP_POP, cmd_of(0, 1, 0, 0), '0);
		send_item(OP_MOVE, cmd_of(0, 0, 1, 0), '0);
		in_valid <= 1'b0;

		// Sender pause: let every outstanding result arrive
		wait_drained();

		// Random segments: fill one side, drain, or mix
		n = 0;
		while (n < RANDOM_ITEMS) begin
			seg_len = $urandom_range(160, 30);
			fav     = 1'($urandom_range(1));
			case ($urandom_range(2))
				0: mode = MODE_FILL;
				1: mode = MODE_DRAIN;
				default: mode = MODE_MIX;
			endcase
			case (mode)
				MODE_FILL: begin push_pct = 80; take_pct = 15; end
				MODE_DRAIN: begin push_pct = 10; take_pct = 85; end
				default: begin push_pct = 45; take_pct = 45; end
			endcase
			for (int k = 0; k < seg_len && n < RANDOM_ITEMS; k++) begin
				// Idling profile by thirds of the random part
				if (n < RANDOM_ITEMS / 3) begin
					snd_idle_pct = 26;
					rcv_idle_pct = 82;
				end else if (n < 2 * RANDOM_ITEMS / 3) begin
					snd_idle_pct = 82;
					rcv_idle_pct = 26;
				end else begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
				// Long output hold while the sender keeps offering
				if (n == 2 * RANDOM_ITEMS / 3 + 10)
					hold_token++;

				r = $urandom_range(99);
				if (r < push_pct)
					o = OP_PUSH;
				else if (r < push_pct + take_pct)
					o = r[0] ? OP_POP : OP_MOVE;
				else
					o = OP_UNUSED;

				c = CMD_W'($urandom_range(15));
				if (mode == MODE_FILL)
					c[CMD_DST_RIGHT] = ($urandom_range(99) < 85) ? fav : !fav;
				else if (mode == MODE_DRAIN)
					c[CMD_SRC_RIGHT] = ($urandom_range(99) < 85) ? fav : !fav;

				case ($urandom_range(9))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = '1;
					3: v = '0;
					default: v = $urandom();
				endcase

				send_item(o, c, v);
				n++;
			end
		end
		in_valid <= 1'b0;

		// Wind down: wait for all results, then idle before the final check
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending_taken.size() != 0) begin
			$error("%0d expected results never arrived", sb.pending_taken.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> filelist.f
rtl/drdm_pkg.sv
rtl/drdm_ram.sv
rtl/drdm_deque.sv
rtl/dual_ring_deque_mover_top.sv
tb/testbench.sv
